@@ src/lru_pr_pkg.sv @@
// shared types and constants for the lru page replacement block
package lru_pr_pkg;

    localparam int PAGE_W      = 16;
    localparam int FRAME_IDX_W = 3;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 4;

    // reset value of the active frame count register
    localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = 4'd4;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              end_of_string;
    } t_in_word;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [COUNT_W-1:0]     hit_total;
        logic [COUNT_W-1:0]     fault_total;
    } t_out_word;

    // outcome of one lookup
    typedef struct packed {
        logic hit;
        logic evict;
    } t_decision;

endpackage

@@ src/lru_pr_lookup.sv @@
// frame search: hit match, empty frame and lru victim selection
module lru_pr_lookup #(
    parameter int MAX_FRAMES = 8,
    parameter int PW         = 16,
    parameter int IW         = 3,
    parameter int RW         = 3
) (
    input  logic [PW-1:0]                  i_page,
    input  logic [lru_pr_pkg::CFG_W-1:0]   i_active_frames,
    input  logic [PW-1:0]                  i_frame_page [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0]          i_frame_valid,
    input  logic [RW-1:0]                  i_frame_rank [MAX_FRAMES],
    output lru_pr_pkg::t_decision          o_dec,
    output logic [MAX_FRAMES-1:0]          o_active,
    output logic [MAX_FRAMES-1:0]          o_sel,
    output logic [IW-1:0]                  o_sel_idx,
    output logic [RW-1:0]                  o_old_rank,
    output logic [PW-1:0]                  o_evicted_page
);

    localparam int MW = $clog2(MAX_FRAMES + 1);
    localparam int LW = (MW > lru_pr_pkg::CFG_W) ? MW : lru_pr_pkg::CFG_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_FRAMES);

    logic [LW-1:0]         cfg_ext;
    logic [LW-1:0]         live;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [IW-1:0]         hit_idx;
    logic [IW-1:0]         empty_idx;
    logic [IW-1:0]         vict_idx;
    logic [RW-1:0]         best;
    logic [PW-1:0]         page_or;
    logic [RW-1:0]         rank_or;

    // zero acts as one frame, anything above the built count as the built count
    assign cfg_ext = LW'(i_active_frames);
    always_comb begin
        if (cfg_ext == '0) begin
            live = LW'(1);
        end else if (cfg_ext > MAX_L) begin
            live = MAX_L;
        end else begin
            live = cfg_ext;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            o_active[i] = (LW'(i) < live);
            match[i]    = o_active[i] && i_frame_valid[i] && (i_frame_page[i] == i_page);
            empty[i]    = o_active[i] && !i_frame_valid[i];
        end
    end

    // lowest index wins
    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (empty[i]) begin
                empty_idx = IW'(i);
            end
        end
    end

    // largest rank, lowest index on a tie
    always_comb begin
        best     = '0;
        vict_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (o_active[i] && (i_frame_rank[i] > best)) begin
                best     = i_frame_rank[i];
                vict_idx = IW'(i);
            end
        end
    end

    always_comb begin
        o_dec.hit   = |match;
        o_dec.evict = 1'b0;
        if (|match) begin
            o_sel_idx = hit_idx;
        end else if (|empty) begin
            o_sel_idx = empty_idx;
        end else begin
            o_sel_idx   = vict_idx;
            o_dec.evict = 1'b1;
        end
    end

    always_comb begin
        page_or = '0;
        rank_or = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            o_sel[i] = (IW'(i) == o_sel_idx);
            page_or  = page_or | (i_frame_page[i] & {PW{o_sel[i]}});
            rank_or  = rank_or | (i_frame_rank[i] & {RW{o_sel[i]}});
        end
    end

    assign o_old_rank     = rank_or;
    assign o_evicted_page = o_dec.evict ? page_or : '0;

endmodule

@@ src/lru_pr_frames.sv @@
// frame table: page, valid and rank registers with their lru update
module lru_pr_frames #(
    parameter int MAX_FRAMES = 8,
    parameter int PW         = 16,
    parameter int IW         = 3,
    parameter int RW         = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [PW-1:0]                 i_page,
    input  logic                          i_end_of_string,
    input  logic [lru_pr_pkg::CFG_W-1:0]  i_active_frames,
    output lru_pr_pkg::t_decision         o_dec,
    output logic [IW-1:0]                 o_sel_idx,
    output logic [PW-1:0]                 o_evicted_page
);

    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_FRAMES - 1);

    logic [PW-1:0]         r_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [RW-1:0]         r_rank [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] n_valid;
    logic [RW-1:0]         n_rank [MAX_FRAMES];

    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] sel;
    logic [RW-1:0]         old_rank;

    lru_pr_lookup #(
        .MAX_FRAMES (MAX_FRAMES),
        .PW         (PW),
        .IW         (IW),
        .RW         (RW)
    ) u_lookup (
        .i_page          (i_page),
        .i_active_frames (i_active_frames),
        .i_frame_page    (r_page),
        .i_frame_valid   (r_valid),
        .i_frame_rank    (r_rank),
        .o_dec           (o_dec),
        .o_active        (active),
        .o_sel           (sel),
        .o_sel_idx       (o_sel_idx),
        .o_old_rank      (old_rank),
        .o_evicted_page  (o_evicted_page)
    );

    // touched frame goes to rank 0, younger valid active frames age by one, end of string clears all
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (i_end_of_string) begin
                n_valid[i] = 1'b0;
                n_rank[i]  = '0;
            end else if (sel[i]) begin
                n_valid[i] = 1'b1;
                n_rank[i]  = '0;
            end else if (active[i] && r_valid[i] && (!o_dec.hit || r_rank[i] < old_rank)
                         && (r_rank[i] < RANK_MAX)) begin
                n_rank[i] = r_rank[i] + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_en) begin
            r_valid <= n_valid;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i_en && sel[i] && !o_dec.hit) begin
                r_page[i] <= i_page;
            end
        end
    end

endmodule

@@ src/lru_page_replacement.sv @@
// top level of the fully associative lru page replacement block
// an accepted word waits in the input register and fires into the result register once that stage is free
// throughput: one word per cycle while the result side does not stall
// the output register lets a new word enter while a finished result waits
// reset (synchronous, active low) clears valid bits, ranks, counters and both stages
// and sets the active frame count to 4; stored page numbers are not cleared
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    input  lru_pr_pkg::t_in_word          i_word,
    output logic                          o_stall,
    // result channel
    output logic                          o_valid,
    output lru_pr_pkg::t_out_word         o_word,
    input  logic                          i_stall,
    // configuration: active frame count
    input  logic                          i_cfg_wr_en,
    input  logic [lru_pr_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    // stored page width: pages are masked to PAGE_BITS and never exceed the field width
    localparam int PW = (PAGE_BITS < lru_pr_pkg::PAGE_W) ? PAGE_BITS : lru_pr_pkg::PAGE_W;
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = IW;
    localparam int FW = lru_pr_pkg::FRAME_IDX_W;

    // configuration register
    logic [lru_pr_pkg::CFG_W-1:0] r_active_frames;

    // input stage
    logic                 r_in_vld;
    lru_pr_pkg::t_in_word r_in;

    // result stage
    logic                  r_out_vld;
    lru_pr_pkg::t_out_word r_out;
    lru_pr_pkg::t_out_word n_out;

    // running counts for the current string
    logic [lru_pr_pkg::COUNT_W-1:0] r_hit_cnt;
    logic [lru_pr_pkg::COUNT_W-1:0] r_fault_cnt;
    logic [lru_pr_pkg::COUNT_W-1:0] n_hit_cnt;
    logic [lru_pr_pkg::COUNT_W-1:0] n_fault_cnt;

    logic                  out_free;
    logic                  fire;
    logic                  in_load;
    logic [PW-1:0]         page_m;
    lru_pr_pkg::t_decision dec;
    logic [IW-1:0]         sel_idx;
    logic [PW-1:0]         ev_page;
    logic [IW+FW-1:0]      sel_idx_ext;

    // handshake: result stage drains when taken, compute fires into a free result stage
    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign in_load  = !r_in_vld || fire;
    assign o_stall  = !in_load;

    assign page_m = r_in.page[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_frames <= lru_pr_pkg::ACTIVE_FRAMES_RST;
        end else if (i_cfg_wr_en) begin
            r_active_frames <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_load) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in <= i_word;
        end
    end

    // frame table and lookup
    lru_pr_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PW         (PW),
        .IW         (IW),
        .RW         (RW)
    ) u_frames (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (fire),
        .i_page          (page_m),
        .i_end_of_string (r_in.end_of_string),
        .i_active_frames (r_active_frames),
        .o_dec           (dec),
        .o_sel_idx       (sel_idx),
        .o_evicted_page  (ev_page)
    );

    // saturating counts, reported including this word
    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_fault_cnt = r_fault_cnt;
        if (dec.hit) begin
            if (r_hit_cnt != '1) begin
                n_hit_cnt = r_hit_cnt + lru_pr_pkg::COUNT_W'(1);
            end
        end else begin
            if (r_fault_cnt != '1) begin
                n_fault_cnt = r_fault_cnt + lru_pr_pkg::COUNT_W'(1);
            end
        end
    end

    // frame index field keeps the low bits of the frame number
    assign sel_idx_ext = (IW + FW)'(sel_idx);

    always_comb begin
        n_out.hit           = dec.hit;
        n_out.frame_index   = sel_idx_ext[FW-1:0];
        n_out.evicted_valid = dec.evict;
        n_out.evicted_page  = lru_pr_pkg::PAGE_W'(ev_page);
        n_out.hit_total     = n_hit_cnt;
        n_out.fault_total   = n_fault_cnt;
    end

    // counters clear after the last word of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
        end else if (fire) begin
            if (r_in.end_of_string) begin
                r_hit_cnt   <= '0;
                r_fault_cnt <= '0;
            end else begin
                r_hit_cnt   <= n_hit_cnt;
                r_fault_cnt <= n_fault_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

    // a word that fires always lands in the result stage
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("fired word did not reach the result stage");

    // end of string leaves both counters at zero
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_string |=> (r_hit_cnt == '0) && (r_fault_cnt == '0))
        else $error("counters not cleared after end of string");

    // a hit never evicts, and no eviction reports a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.hit |-> !o_word.evicted_valid)
        else $error("hit reported an eviction");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.evicted_valid |-> (o_word.evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    // input stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("input stalled without a full pipeline");

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the lru page replacement block with its own lru frame tracker
`timescale 1ns / 100ps

// shadow of the frame table: predicts each result word and checks the ones that come out
class lru_tracker;
    localparam int N_FRAMES = 8;

    logic [lru_pr_pkg::PAGE_W-1:0]  page_of [N_FRAMES];
    bit                             valid_of [N_FRAMES];
    int unsigned                    rank_of [N_FRAMES];
    logic [lru_pr_pkg::COUNT_W-1:0] hits;
    logic [lru_pr_pkg::COUNT_W-1:0] faults;
    logic [lru_pr_pkg::CFG_W-1:0]   frame_count;
    lru_pr_pkg::t_out_word          expected_q[$];
    int unsigned                    mismatches;

    function new();
        for (int i = 0; i < N_FRAMES; i++) begin
            page_of[i] = '0;
        end
        clear_string();
        frame_count = lru_pr_pkg::ACTIVE_FRAMES_RST;
        mismatches  = 0;
    endfunction

    function void clear_string();
        for (int i = 0; i < N_FRAMES; i++) begin
            valid_of[i] = 1'b0;
            rank_of[i]  = 0;
        end
        hits   = '0;
        faults = '0;
    endfunction

    function void set_frame_count(logic [lru_pr_pkg::CFG_W-1:0] value);
        frame_count = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // work out the result of one accepted reference and queue it
    function void note_reference(lru_pr_pkg::t_in_word w);
        int unsigned           n;
        int unsigned           f;
        int unsigned           old_rank;
        int unsigned           best;
        bit                    is_hit;
        bit                    found_free;
        lru_pr_pkg::t_out_word r;
        r      = '0;
        f      = 0;
        is_hit = 1'b0;
        if (frame_count == 0) begin
            n = 1;
        end else if (frame_count > N_FRAMES) begin
            n = N_FRAMES;
        end else begin
            n = frame_count;
        end
        // search the active frames, lowest index first
        for (int i = 0; i < n; i++) begin
            if (!is_hit && valid_of[i] && page_of[i] == w.page) begin
                f      = i;
                is_hit = 1'b1;
            end
        end
        if (is_hit) begin
            old_rank = rank_of[f];
            if (hits != '1) hits++;
        end else begin
            found_free = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found_free && !valid_of[i]) begin
                    f          = i;
                    found_free = 1'b1;
                end
            end
            if (!found_free) begin
                // victim: largest rank, lowest index on a tie
                best = 0;
                f    = 0;
                for (int i = 0; i < n; i++) begin
                    if (rank_of[i] > best) begin
                        best = rank_of[i];
                        f    = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = page_of[f];
            end
            page_of[f]  = w.page;
            valid_of[f] = 1'b1;
            old_rank    = N_FRAMES;
            if (faults != '1) faults++;
        end
        // age every other valid active frame that was more recent
        for (int i = 0; i < n; i++) begin
            if (i != f && valid_of[i] && rank_of[i] < old_rank && rank_of[i] < N_FRAMES - 1)
                rank_of[i]++;
        end
        rank_of[f] = 0;
        r.hit         = is_hit;
        r.frame_index = f[lru_pr_pkg::FRAME_IDX_W-1:0];
        r.hit_total   = hits;
        r.fault_total = faults;
        expected_q.push_back(r);
        if (w.end_of_string) clear_string();
    endfunction

    task report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check_result(lru_pr_pkg::t_out_word got);
        lru_pr_pkg::t_out_word want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected: %h", got));
            return;
        end
        want = expected_q.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit want %b got %b", want.hit, got.hit));
        if (got.frame_index !== want.frame_index)
            report_mismatch($sformatf("frame_index want %0d got %0d",
                                      want.frame_index, got.frame_index));
        if (got.evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid want %b got %b",
                                      want.evicted_valid, got.evicted_valid));
        if (got.evicted_page !== want.evicted_page)
            report_mismatch($sformatf("evicted_page want %h got %h",
                                      want.evicted_page, got.evicted_page));
        if (got.hit_total !== want.hit_total)
            report_mismatch($sformatf("hit_total want %0d got %0d",
                                      want.hit_total, got.hit_total));
        if (got.fault_total !== want.fault_total)
            report_mismatch($sformatf("fault_total want %0d got %0d",
                                      want.fault_total, got.fault_total));
    endtask
endclass

module testbench;

    // generous bound: about a thousand words, each with random idle and stall gaps
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 14;

    logic                          i_clk       = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    lru_pr_pkg::t_in_word          in_word     = '0;
    logic                          o_stall;
    logic                          o_valid;
    lru_pr_pkg::t_out_word         o_word;
    logic                          out_stall   = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [lru_pr_pkg::CFG_W-1:0]  cfg_wr_data = '0;

    // high during the stretch where neither side idles
    logic                          no_idle     = 1'b0;
    int unsigned                   cycle_count = 0;

    // pages of the current string come mostly from a small window
    logic [lru_pr_pkg::PAGE_W-1:0] pool_base   = '0;
    int unsigned                   pool_span   = 1;

    lru_tracker                    tracker;

    lru_page_replacement dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .i_word        (in_word),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_word        (o_word),
        .i_stall       (out_stall),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    // result side stalls at random except during the quiet stretch
    always @(posedge i_clk) begin
        out_stall <= !no_idle && ($urandom_range(99) < 34);
    end

    // watch both channels; values read here are the ones from just before the edge
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !o_stall) tracker.note_reference(in_word);
            if (o_valid && !out_stall) tracker.check_result(o_word);
        end
    end

    // cycle counter guards against a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic lru_pr_pkg::t_in_word mk(logic [lru_pr_pkg::PAGE_W-1:0] page,
                                                logic eos);
        lru_pr_pkg::t_in_word w;
        w.page          = page;
        w.end_of_string = eos;
        return w;
    endfunction

    // present one word, with a random gap first, and hold it until accepted
    task automatic send_word(input lru_pr_pkg::t_in_word w);
        while (!no_idle && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and wait until every expected result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
        @(posedge i_clk);
    endtask

    // single write of the frame count register, only while the block is idle
    task automatic write_frame_count(input logic [lru_pr_pkg::CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_frame_count(value);
    endtask

    // pick a new page window up to four pages wider than the live frames, so hits and evictions mix
    task automatic new_pool(input logic [lru_pr_pkg::CFG_W-1:0] count);
        int unsigned n;
        n = (count == 0) ? 1 : ((count > 8) ? 8 : count);
        pool_base = lru_pr_pkg::PAGE_W'($urandom);
        pool_span = n + $urandom_range(4);
    endtask

    function automatic lru_pr_pkg::t_in_word random_reference();
        lru_pr_pkg::t_in_word w;
        if ($urandom_range(99) < 80)
            w.page = pool_base + lru_pr_pkg::PAGE_W'($urandom_range(pool_span - 1));
        else
            w.page = lru_pr_pkg::PAGE_W'($urandom);
        w.end_of_string = ($urandom_range(99) < 4);
        return w;
    endfunction

    // one setting of the frame count, then a run of random strings
    task automatic run_phase(input logic [lru_pr_pkg::CFG_W-1:0] count,
                             input int unsigned n_words, input bit hold_midway);
        lru_pr_pkg::t_in_word w;
        drain_results();
        write_frame_count(count);
        new_pool(count);
        for (int k = 0; k < n_words; k++) begin
            if (hold_midway && k == n_words / 2) drain_results();
            w = random_reference();
            send_word(w);
            if (w.end_of_string) new_pool(count);
        end
    endtask

    initial begin
        int plan [N_PHASES];
        tracker = new();
        plan = '{1, 8, 0, 15, 3, 2, 7, 9, 5, 6, 12, 4, 0, 0};
        // two settings drawn at random
        plan[12] = $urandom_range(15);
        plan[13] = $urandom_range(15);

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset frame count of four
        send_word(mk(16'h0000, 1'b0));  // fill empty frames in order
        send_word(mk(16'hFFFF, 1'b0));
        send_word(mk(16'h0000, 1'b0));  // hit on an older frame
        send_word(mk(16'h1234, 1'b0));
        send_word(mk(16'h8001, 1'b0));  // table now full
        send_word(mk(16'hFFFF, 1'b0));
        send_word(mk(16'h5555, 1'b0));  // miss with a full table evicts the lru frame
        send_word(mk(16'hAAAA, 1'b0));
        send_word(mk(16'hFFFF, 1'b0));
        send_word(mk(16'hFFFF, 1'b0));  // hit on the most recent frame
        send_word(mk(16'h5555, 1'b1));  // end of string on a hit
        send_word(mk(16'h5555, 1'b0));  // table and counts start over
        send_word(mk(16'h0001, 1'b1));  // string of a single word
        send_word(mk(16'h0001, 1'b1));

        // single frame: every new page after the first evicts
        drain_results();
        write_frame_count(4'd1);
        send_word(mk(16'h0002, 1'b0));
        send_word(mk(16'h0002, 1'b0));
        send_word(mk(16'h0003, 1'b0));
        send_word(mk(16'h0002, 1'b0));

        // raise to all frames mid-string; the hidden frames, never filled, start out empty
        drain_results();
        write_frame_count(4'd8);
        for (int k = 0; k < 8; k++) begin
            send_word(mk(lru_pr_pkg::PAGE_W'(16'h0100 + k), 1'b0));
        end
        send_word(mk(16'h0002, 1'b0));
        send_word(mk(16'hBEEF, 1'b1));

        // random phases; one quiet stretch, a few midway holds
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 5) no_idle <= 1'b1;
            if (p == 6) no_idle <= 1'b0;
            run_phase(plan[p][lru_pr_pkg::CFG_W-1:0], 70, (p % 3) == 1);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d result words never came",
                                              tracker.pending()));
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
